// ----- src/ordered_deadline_timer_table_defines.svh -----
// Assertion helpers for the deadline timer table.
// Each expects clk and rst_n in scope.
`ifndef ORDERED_DEADLINE_TIMER_TABLE_DEFINES_SVH
`define ORDERED_DEADLINE_TIMER_TABLE_DEFINES_SVH

// same-cycle implication
`define ODTT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odtt: same-cycle check failed");

// next-cycle implication
`define ODTT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odtt: next-cycle check failed");

`endif

// ----- src/odtt_pkg.sv -----
`timescale 1ns / 1ps
package odtt_pkg;

    localparam int ACTION_W  = 2;
    localparam int SLOT_ID_W = 4;
    localparam int TIME_W    = 63;
    localparam int WAIT_W    = 30;

    localparam int NUM_SLOTS_DEF  = 16;
    localparam int FIRE_BATCH_DEF = 16;
    // most results one tick may produce
    localparam int MAX_RESULTS    = 16;

    localparam logic [WAIT_W-1:0] WAIT_RESET = 30'd100000000;

    localparam logic [ACTION_W-1:0] ACT_ARM    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DISARM = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;

    typedef struct packed {
        logic arm;         // write deadline, append if newly armed
        logic scan_start;  // clear scan counters
        logic ord_rd;      // read list entry at read pointer
        logic dl_rd;       // read deadline of that entry
        logic eval;        // decide fire/keep/drop for the entry
        logic scan_end;    // commit compacted count
        logic calc;        // wait difference
        logic emit_last;   // load final word of a tick
    } ctrl_cmd_t;

    typedef struct packed {
        logic arm_ok;
        logic rm_ok;
        logic tick;
        logic scan_done;
        logic eval_stall;
        logic out_full;
    } ctrl_sts_t;

endpackage

// ----- src/odtt_in_if.sv -----
`timescale 1ns / 1ps
interface odtt_in_if;
    logic                             valid;
    logic                             ready;
    logic [odtt_pkg::ACTION_W-1:0]    action;
    logic [odtt_pkg::SLOT_ID_W-1:0]   slot_id;
    logic [odtt_pkg::TIME_W-1:0]      due_ns;
    logic [odtt_pkg::TIME_W-1:0]      now_ns;

    modport source (output valid, action, slot_id, due_ns, now_ns, input ready);
    modport sink   (input valid, action, slot_id, due_ns, now_ns, output ready);
endinterface

// ----- src/odtt_out_if.sv -----
`timescale 1ns / 1ps
interface odtt_out_if;
    logic                             valid;
    logic                             ready;
    logic                             fired_valid;
    logic [odtt_pkg::SLOT_ID_W-1:0]   fired_slot;
    logic [odtt_pkg::WAIT_W-1:0]      wait_ns;
    logic                             last;

    modport source (output valid, fired_valid, fired_slot, wait_ns, last, input ready);
    modport sink   (input valid, fired_valid, fired_slot, wait_ns, last, output ready);
endinterface

// ----- src/odtt_cfg_if.sv -----
`timescale 1ns / 1ps
interface odtt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [odtt_pkg::WAIT_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/odtt_ram.sv -----
`timescale 1ns / 1ps
module odtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/odtt_ctrl.sv -----
`timescale 1ns / 1ps
module odtt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  odtt_pkg::ctrl_sts_t sts,
    output odtt_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ORD,
        S_DL,
        S_EVAL,
        S_CALC,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.arm_ok)
                begin
                    cmd.arm    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.rm_ok || sts.tick)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_ORD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ORD:
            begin
                if (sts.scan_done)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = sts.tick ? S_CALC : S_IDLE;
                end
                else
                begin
                    cmd.ord_rd = 1'b1;
                    state_next = S_DL;
                end
            end
            S_DL:
            begin
                cmd.dl_rd  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                // a second fire needs the output register to flush the held one
                if (!sts.eval_stall)
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_ORD;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_full)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

// ----- src/odtt_datapath.sv -----
`timescale 1ns / 1ps
module odtt_datapath #(
    parameter int NUM_SLOTS  = odtt_pkg::NUM_SLOTS_DEF,
    parameter int FIRE_BATCH = odtt_pkg::FIRE_BATCH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_take,
    input  logic [odtt_pkg::ACTION_W-1:0]    in_action,
    input  logic [odtt_pkg::SLOT_ID_W-1:0]   in_slot_id,
    input  logic [odtt_pkg::TIME_W-1:0]      in_due_ns,
    input  logic [odtt_pkg::TIME_W-1:0]      in_now_ns,
    input  logic                             cfg_take,
    input  logic [odtt_pkg::WAIT_W-1:0]      cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_fired_valid,
    output logic [odtt_pkg::SLOT_ID_W-1:0]   out_fired_slot,
    output logic [odtt_pkg::WAIT_W-1:0]      out_wait_ns,
    output logic                             out_last,
    input  odtt_pkg::ctrl_cmd_t              ctl,
    output odtt_pkg::ctrl_sts_t              sts
);

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int CW    = $clog2(NUM_SLOTS + 1);
    localparam int LIMIT = (FIRE_BATCH < odtt_pkg::MAX_RESULTS) ? FIRE_BATCH
                                                                 : odtt_pkg::MAX_RESULTS;
    localparam int NW    = $clog2(LIMIT + 1);
    localparam int IdW   = odtt_pkg::SLOT_ID_W;
    localparam int TW    = odtt_pkg::TIME_W;
    localparam int WW    = odtt_pkg::WAIT_W;
    localparam int AW    = odtt_pkg::ACTION_W;

    // captured item
    logic [AW-1:0]        act_reg;
    logic [IdW-1:0]       slot_reg;
    logic [TW-1:0]        dl_reg;
    logic [TW-1:0]        now_reg;

    // list and scan state
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        r_reg;
    logic [CW-1:0]        w_reg;
    logic [NW-1:0]        n_reg;
    logic [NUM_SLOTS-1:0] armed_reg;
    logic                 any_reg;
    logic                 pend_valid_reg;
    logic [SW-1:0]        s_reg;
    logic [SW-1:0]        pend_reg;
    logic [TW-1:0]        next_reg;
    logic                 due_reg;
    logic [TW-1:0]        diff_reg;
    logic [WW-1:0]        maxw_reg;

    logic                 out_valid_reg;
    logic                 out_fv_reg;
    logic [IdW-1:0]       out_slot_reg;
    logic [WW-1:0]        out_wait_reg;
    logic                 out_last_reg;

    logic                 is_arm;
    logic                 is_dis;
    logic                 is_tick;
    logic                 slot_ok;
    logic [SW-1:0]        slot_idx;
    logic                 arm_new;
    logic [SW-1:0]        ord_rdata;
    logic [TW-1:0]        dl_rdata;
    logic                 due;
    logic                 fire;
    logic                 keep;
    logic                 out_full;
    logic                 load_pend;
    logic                 ord_we;
    logic [SW-1:0]        ord_waddr;
    logic [WW-1:0]        wait_final;

    assign is_arm   = (act_reg == odtt_pkg::ACT_ARM);
    assign is_dis   = (act_reg == odtt_pkg::ACT_DISARM);
    assign is_tick  = (act_reg == odtt_pkg::ACT_TICK);
    assign slot_ok  = (int'(slot_reg) < NUM_SLOTS);
    assign slot_idx = SW'(slot_reg);
    assign arm_new  = is_arm && slot_ok && !armed_reg[slot_idx]
                      && (count_reg < CW'(NUM_SLOTS));

    assign due       = (dl_rdata <= now_reg);
    assign fire      = is_tick && due && (n_reg < NW'(LIMIT));
    assign keep      = is_tick ? !fire : (s_reg != slot_idx);
    assign out_full  = out_valid_reg && !out_ready;
    assign load_pend = ctl.eval && fire && pend_valid_reg;

    assign ord_we    = (ctl.arm && arm_new) || (ctl.eval && keep);
    assign ord_waddr = ctl.arm ? count_reg[SW-1:0] : w_reg[SW-1:0];

    always_comb
    begin
        if (!any_reg)
        begin
            wait_final = maxw_reg;
        end
        else if (due_reg)
        begin
            wait_final = '0;
        end
        else if (diff_reg > TW'(maxw_reg))
        begin
            wait_final = maxw_reg;
        end
        else
        begin
            wait_final = diff_reg[WW-1:0];
        end
    end

    assign sts.arm_ok     = is_arm && slot_ok;
    assign sts.rm_ok      = is_dis && slot_ok && armed_reg[slot_idx];
    assign sts.tick       = is_tick;
    assign sts.scan_done  = (r_reg == count_reg);
    assign sts.eval_stall = fire && pend_valid_reg && out_full;
    assign sts.out_full   = out_full;

    // armed list in arming order, compacted in place during a scan
    odtt_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_SLOTS)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ctl.arm ? slot_idx : s_reg),
        .re    (ctl.ord_rd),
        .raddr (r_reg[SW-1:0]),
        .rdata (ord_rdata)
    );

    odtt_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_SLOTS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ctl.arm && slot_ok),
        .waddr (slot_idx),
        .wdata (dl_reg),
        .re    (ctl.dl_rd),
        .raddr (ord_rdata),
        .rdata (dl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            r_reg          <= '0;
            w_reg          <= '0;
            n_reg          <= '0;
            armed_reg      <= '0;
            any_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            maxw_reg       <= odtt_pkg::WAIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_take)
            begin
                maxw_reg <= cfg_data;
            end
            if (ctl.arm && arm_new)
            begin
                count_reg           <= count_reg + 1'b1;
                armed_reg[slot_idx] <= 1'b1;
            end
            if (ctl.scan_start)
            begin
                r_reg          <= '0;
                w_reg          <= '0;
                n_reg          <= '0;
                any_reg        <= 1'b0;
                pend_valid_reg <= 1'b0;
                if (is_dis)
                begin
                    armed_reg[slot_idx] <= 1'b0;
                end
            end
            if (ctl.eval)
            begin
                r_reg <= r_reg + 1'b1;
                if (fire)
                begin
                    n_reg            <= n_reg + 1'b1;
                    pend_valid_reg   <= 1'b1;
                    armed_reg[s_reg] <= 1'b0;
                end
                if (keep)
                begin
                    w_reg <= w_reg + 1'b1;
                    if (is_tick)
                    begin
                        any_reg <= 1'b1;
                    end
                end
            end
            if (ctl.scan_end)
            begin
                count_reg <= w_reg;
            end
            if (load_pend || ctl.emit_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg  <= in_action;
            slot_reg <= in_slot_id;
            dl_reg   <= in_due_ns;
            now_reg  <= in_now_ns;
        end
        if (ctl.dl_rd)
        begin
            s_reg <= ord_rdata;
        end
        if (ctl.eval && fire)
        begin
            pend_reg <= s_reg;
        end
        if (ctl.eval && keep && is_tick && (!any_reg || dl_rdata < next_reg))
        begin
            next_reg <= dl_rdata;
        end
        if (ctl.calc)
        begin
            due_reg  <= (next_reg <= now_reg);
            diff_reg <= next_reg - now_reg;
        end
        // held fire goes out as a non-final word when the next one arrives
        if (load_pend)
        begin
            out_fv_reg   <= 1'b1;
            out_slot_reg <= IdW'(pend_reg);
            out_wait_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else if (ctl.emit_last)
        begin
            out_fv_reg   <= pend_valid_reg;
            out_slot_reg <= pend_valid_reg ? IdW'(pend_reg) : '0;
            out_wait_reg <= wait_final;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_fired_valid = out_fv_reg;
    assign out_fired_slot  = out_slot_reg;
    assign out_wait_ns     = out_wait_reg;
    assign out_last        = out_last_reg;

endmodule

// ----- src/ordered_deadline_timer_table.sv -----
// Deadline timer table with an armed list kept in arming order.
// Arm, unknown action, disarm of an unarmed slot: done after decode. Disarm: a list scan.
// Tick: scans the list, with a list read, deadline read and compare per entry.
// A fired word is held until the next fire or the final word; a held-off output stalls.
// Reset (rst_n low, async): list empty, all slots disarmed, max wait 100000000 ns.
`timescale 1ns / 1ps
`include "ordered_deadline_timer_table_defines.svh"
module ordered_deadline_timer_table #(
    parameter int NUM_SLOTS  = odtt_pkg::NUM_SLOTS_DEF,
    parameter int FIRE_BATCH = odtt_pkg::FIRE_BATCH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    odtt_in_if.sink     cmd,
    odtt_out_if.source  rsp,
    odtt_cfg_if.sink    cfg
);

    odtt_pkg::ctrl_cmd_t ctl_cmd;
    odtt_pkg::ctrl_sts_t ctl_sts;
    logic                in_ready;

    assign cmd.ready = in_ready;
    assign cfg.ready = 1'b1;

    odtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    odtt_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .FIRE_BATCH (FIRE_BATCH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_take         (cmd.valid && in_ready),
        .in_action       (cmd.action),
        .in_slot_id      (cmd.slot_id),
        .in_due_ns       (cmd.due_ns),
        .in_now_ns       (cmd.now_ns),
        .cfg_take        (cfg.valid),
        .cfg_data        (cfg.data),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .out_fired_valid (rsp.fired_valid),
        .out_fired_slot  (rsp.fired_slot),
        .out_wait_ns     (rsp.wait_ns),
        .out_last        (rsp.last),
        .ctl             (ctl_cmd),
        .sts             (ctl_sts)
    );

    `ODTT_ASSERT_IMPL(a_quiet_on_accept, cmd.valid && cmd.ready, ctl_cmd == '0)
    `ODTT_ASSERT_IMPL(a_no_stalled_eval, ctl_cmd.eval, !ctl_sts.eval_stall)
    `ODTT_ASSERT_IMPL(a_no_emit_when_full, ctl_cmd.emit_last, !ctl_sts.out_full)
    `ODTT_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready)

endmodule
